### rtl/mbf_pkg.sv
package mbf_pkg;

  // Default build limits.
  localparam int MAX_SIDE_DEF   = 4096;
  localparam int MAX_LEVELS_DEF = 13;

  // Fixed field widths.
  localparam int RGBA_W  = 32;
  localparam int LEVEL_W = 4;
  localparam int PAIR_W  = 36;
  localparam int CFG_W   = 13;
  localparam int CFG_IDX_W = 8;

  // Side length after reset.
  localparam int SIDE_RESET = 4096;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 8'd0,
    REG_IMAGE_HEIGHT = 8'd1
  } cfg_reg_t;

  // Per-step control from the level logic to the walker.
  typedef struct packed {
    logic cont;    // the block average goes on to the next level
    logic mem_wr;  // store the horizontal pair sum of an even row
  } step_ctl_t;

  // Four 9-bit channel sums of two pixels, packed at bits 0, 9, 18 and 27.
  function automatic logic [PAIR_W-1:0] pair_sum(input logic [RGBA_W-1:0] a,
                                                 input logic [RGBA_W-1:0] b);
    logic [PAIR_W-1:0] r;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      r[9*c +: 9] = {1'b0, a[8*c +: 8]} + {1'b0, b[8*c +: 8]};
    end
    return r;
  endfunction

  // Truncating average of a 2x2 block from two pair sums.
  function automatic logic [RGBA_W-1:0] block_average(input logic [PAIR_W-1:0] top,
                                                      input logic [PAIR_W-1:0] bot);
    logic [RGBA_W-1:0] r;
    logic [9:0]        s;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      s = {1'b0, top[9*c +: 9]} + {1'b0, bot[9*c +: 9]};
      r[8*c +: 8] = s[9:2];
    end
    return r;
  endfunction

endpackage

### rtl/mbf_pair_mem.sv
module mbf_pair_mem
  import mbf_pkg::*;
#(
  parameter int DEPTH = MAX_SIDE_DEF,
  parameter int AW    = $clog2(MAX_SIDE_DEF)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [PAIR_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [PAIR_W-1:0] rd_data
);

  logic [PAIR_W-1:0] mem_r [DEPTH];
  logic [PAIR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/mbf_level_ctrl.sv
module mbf_level_ctrl
  import mbf_pkg::*;
#(
  parameter int MAX_SIDE   = MAX_SIDE_DEF,
  parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  restart,
  input  logic                                  adv,
  input  logic [$clog2(MAX_LEVELS)-1:0]         lvl,
  input  logic [$clog2(MAX_SIDE+1)-1:0]         side_w,
  input  logic [$clog2(MAX_SIDE+1)-1:0]         side_h,
  input  logic [$clog2(MAX_LEVELS+1)-1:0]       levels,
  input  logic [$clog2(MAX_SIDE+1):0]           off,
  input  logic [RGBA_W-1:0]                     cur_pix,
  output logic [$clog2(MAX_SIDE)-1:0]           pos_x,
  output logic [$clog2(MAX_SIDE)-1:0]           pos_y,
  output logic [$clog2(MAX_SIDE+1)-1:0]         next_w,
  output logic [PAIR_W-1:0]                     pair,
  output logic [$clog2(MAX_SIDE)-1:0]           addr,
  output step_ctl_t                             ctl
);

  localparam int CW  = $clog2(MAX_SIDE);
  localparam int SW  = $clog2(MAX_SIDE + 1);
  localparam int IW  = SW + 1;
  localparam int LCW = $clog2(MAX_LEVELS + 1);

  logic [CW-1:0]     col_r  [MAX_LEVELS];
  logic [CW-1:0]     row_r  [MAX_LEVELS];
  logic [RGBA_W-1:0] hold_r [MAX_LEVELS];

  logic [SW-1:0] wl, hl, hn;
  logic [SW-1:0] x_ext, y_ext;
  logic          wrap_x, wrap_y;
  logic [IW-1:0] idx;
  logic          in_block, idx_ok, pair_ok, hold_wr;

  always_comb begin
    pos_x  = col_r[lvl];
    pos_y  = row_r[lvl];
    wl     = side_w >> lvl;
    hl     = side_h >> lvl;
    next_w = wl >> 1;
    hn     = hl >> 1;
    x_ext  = SW'(pos_x);
    y_ext  = SW'(pos_y);
    wrap_x = (x_ext + SW'(1)) >= wl;
    wrap_y = (y_ext + SW'(1)) >= hl;

    // The pixel lies inside a complete 2x2 block of a level that has a successor.
    in_block = ((LCW'(lvl) + LCW'(1)) < levels) && (next_w != '0) && (hn != '0) &&
               (x_ext < {next_w[SW-2:0], 1'b0}) && (y_ext < {hn[SW-2:0], 1'b0});
    idx      = off + IW'(pos_x >> 1);
    idx_ok   = idx < IW'(MAX_SIDE);
    addr     = idx[CW-1:0];
    pair     = pair_sum(hold_r[lvl], cur_pix);
    hold_wr  = in_block && !pos_x[0];
    pair_ok  = in_block && pos_x[0] && idx_ok;
    ctl.mem_wr = pair_ok && !pos_y[0];
    ctl.cont   = pair_ok && pos_y[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        col_r[i] <= '0;
        row_r[i] <= '0;
      end
    end else if (adv) begin
      if (wrap_x) begin
        col_r[lvl] <= '0;
        row_r[lvl] <= wrap_y ? '0 : CW'(y_ext + SW'(1));
      end else begin
        col_r[lvl] <= CW'(x_ext + SW'(1));
      end
    end
  end

  // Even-column pixels wait here for their right neighbor.
  always_ff @(posedge clk) begin
    if (adv && hold_wr) begin
      hold_r[lvl] <= cur_pix;
    end
  end

endmodule

### rtl/mipmap_box_filter_chain_top.sv
// Mip chain generator with a 2x2 box filter. RGBA8 pixels of the base image
// enter in raster order on the in_ stream, one 32-bit word per pixel, with
// channel 0 in the low byte. Every input pixel leaves at once as a level 0
// word, followed by one word for each coarser level whose 2x2 block it
// completes; the value there is the per-channel truncating average of the
// four source pixels. Output words carry the level and the column and row
// within that level, and tlast marks the final word caused by one input.
// Level l measures (W >> l) x (H >> l), so an odd trailing column or row is
// dropped, and the chain has as many levels as the larger side has bits,
// capped at MAX_LEVELS. Set the width (register 0) and height (register 1)
// while the block is idle; either write restarts the frame, and a value of
// 0 counts as 1 while values above MAX_SIDE count as MAX_SIDE. After the
// last pixel of a frame every level wraps, so the next pixel starts a new
// frame. Throughput: one output word per clock while the output is not
// stalled, and an input pixel gives 1 + k words, where k is the number of
// coarser levels it completes. This is set by the level walker, which
// visits one level per cycle unless the output stalls, because the average
// of each level comes from the pair-sum memory read issued in the step of
// the level above. The next pixel is taken in the same cycle as the last
// word of the previous one leaves the walker. No clearing pass is run after reset.
module mipmap_box_filter_chain_top
  import mbf_pkg::*;
#(
  parameter int MAX_SIDE   = MAX_SIDE_DEF,
  parameter int MAX_LEVELS = MAX_LEVELS_DEF,
  localparam int CW        = $clog2(MAX_SIDE),
  localparam int OUT_BITS  = LEVEL_W + 2 * CW + RGBA_W,
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input stream. tdata: pixel_rgba [31:0].
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [RGBA_W-1:0]    in_tdata,
  // Result stream. tdata from bit 0 up: mip_level (4), pixel_x (CW),
  // pixel_y (CW), out_rgba (32), zero fill. tlast: last_of_run.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata,
  output logic                 out_tlast,
  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int SW  = $clog2(MAX_SIDE + 1);
  localparam int IW  = SW + 1;
  localparam int LVW = $clog2(MAX_LEVELS);
  localparam int LCW = $clog2(MAX_LEVELS + 1);

  // Configuration registers hold the raw written values.
  logic [CFG_W-1:0] width_raw_r, height_raw_r;
  logic             cfg_we, restart;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_comb begin
    restart = 1'b0;
    unique case (cfg_index) inside
      REG_IMAGE_WIDTH,
      REG_IMAGE_HEIGHT: restart = cfg_we;
      default:          restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_raw_r  <= CFG_W'(SIDE_RESET);
      height_raw_r <= CFG_W'(SIDE_RESET);
    end else if (cfg_we) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        width_raw_r <= cfg_data;
      end
      if (cfg_index == REG_IMAGE_HEIGHT) begin
        height_raw_r <= cfg_data;
      end
    end
  end

  // Clamped sides and the level count (bit length of the larger side).
  logic [SW-1:0]  side_w, side_h, side_max;
  logic [LCW-1:0] levels;
  int             nbits;

  always_comb begin
    if (width_raw_r == '0) begin
      side_w = SW'(1);
    end else if (32'(width_raw_r) > MAX_SIDE) begin
      side_w = SW'(MAX_SIDE);
    end else begin
      side_w = SW'(width_raw_r);
    end
    if (height_raw_r == '0) begin
      side_h = SW'(1);
    end else if (32'(height_raw_r) > MAX_SIDE) begin
      side_h = SW'(MAX_SIDE);
    end else begin
      side_h = SW'(height_raw_r);
    end
    side_max = (side_w > side_h) ? side_w : side_h;
    nbits = 0;
    for (int i = 0; i < SW; i++) begin
      if (side_max[i]) begin
        nbits = i + 1;
      end
    end
    levels = (nbits > MAX_LEVELS) ? LCW'(MAX_LEVELS) : LCW'(nbits);
  end

  // Level walker: one level of the current pixel per cycle while the output is not stalled.
  logic              busy_r, busy_nxt;
  logic [LVW-1:0]    lvl_r, lvl_nxt;
  logic [IW-1:0]     off_r, off_nxt;
  logic [RGBA_W-1:0] pix_r, pix_nxt;
  logic [PAIR_W-1:0] pair_r, pair_nxt;
  logic              avg_r, avg_nxt;

  logic              adv, in_accept, mem_rd;
  logic [RGBA_W-1:0] cur_pix;
  logic [PAIR_W-1:0] rd_data, pair;
  logic [CW-1:0]     pos_x, pos_y, addr;
  logic [SW-1:0]     next_w;
  step_ctl_t         ctl;

  logic              out_valid_r;
  logic [OUT_W-1:0]  out_data_r;
  logic              out_last_r;

  // A step goes ahead whenever the output register is free or being drained.
  assign adv       = busy_r && (!out_valid_r || out_tready);
  assign in_tready = !busy_r || (adv && !ctl.cont);
  assign in_accept = in_tvalid && in_tready;
  assign mem_rd    = adv && ctl.cont;

  // Coarser levels take the average of the stored top pair and the new bottom pair.
  assign cur_pix = avg_r ? block_average(rd_data, pair_r) : pix_r;

  mbf_level_ctrl #(
    .MAX_SIDE   (MAX_SIDE),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_level (
    .clk     (clk),
    .rst_n   (rst_n),
    .restart (restart),
    .adv     (adv),
    .lvl     (lvl_r),
    .side_w  (side_w),
    .side_h  (side_h),
    .levels  (levels),
    .off     (off_r),
    .cur_pix (cur_pix),
    .pos_x   (pos_x),
    .pos_y   (pos_y),
    .next_w  (next_w),
    .pair    (pair),
    .addr    (addr),
    .ctl     (ctl)
  );

  // Pair sums of even rows; each level owns a region after those above it.
  mbf_pair_mem #(
    .DEPTH (MAX_SIDE),
    .AW    (CW)
  ) u_pair_mem (
    .clk     (clk),
    .wr_en   (adv && ctl.mem_wr),
    .wr_addr (addr),
    .wr_data (pair),
    .rd_en   (mem_rd),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  always_comb begin
    busy_nxt = busy_r;
    lvl_nxt  = lvl_r;
    off_nxt  = off_r;
    pix_nxt  = pix_r;
    pair_nxt = pair_r;
    avg_nxt  = avg_r;
    if (adv && ctl.cont) begin
      lvl_nxt  = lvl_r + LVW'(1);
      off_nxt  = off_r + IW'(next_w);
      pair_nxt = pair;
      avg_nxt  = 1'b1;
    end else if (adv) begin
      busy_nxt = 1'b0;
    end
    if (in_accept) begin
      busy_nxt = 1'b1;
      lvl_nxt  = '0;
      off_nxt  = '0;
      pix_nxt  = in_tdata;
      avg_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      avg_r  <= 1'b0;
      lvl_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      avg_r  <= avg_nxt;
      lvl_r  <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_r  <= off_nxt;
    pix_r  <= pix_nxt;
    pair_r <= pair_nxt;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= OUT_W'({cur_pix, pos_y, pos_x, LEVEL_W'(lvl_r)});
      out_last_r <= !ctl.cont;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // An averaged pixel never belongs to the base level.
  a_avg_not_base: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && avg_r |-> lvl_r != '0)
    else $error("averaged pixel at base level");

  // The walker stays inside the level chain of the current image.
  a_lvl_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> LCW'(lvl_r) < levels)
    else $error("walker level beyond chain");

  // A continuing step keeps the walker busy on the averaged pixel.
  a_cont_keeps_busy: assert property (@(posedge clk) disable iff (!rst_n)
    adv && ctl.cont |=> busy_r && avg_r && lvl_r == $past(lvl_r) + LVW'(1))
    else $error("cascade step lost");

  // While a run is stalled, no pixel is accepted.
  a_no_accept_midrun: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !adv |-> !in_tready)
    else $error("input taken while a run is stalled");

endmodule
